>>> rtl/krt_pkg.sv
// shared constants and types of the keyed record table
`default_nettype none
package krt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int KIND_W  = 2;
  localparam int KEY_W   = 32;
  localparam int SEAT_W  = 16;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [KEY_W-1:0] found_key;
    logic [SEAT_W-1:0]       found_seats;
    logic [SLOT_W-1:0]       slot_position;
    logic [COUNT_W-1:0]      entries_held;
    logic                    last_result;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/krt_cmd_if.sv
// command channel of the keyed record table
`default_nettype none
interface krt_cmd_if import krt_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic signed [KEY_W-1:0] record_key;
  logic [SEAT_W-1:0]       seat_count;

  modport source (output valid, kind, record_key, seat_count, input ready);
  modport sink (input valid, kind, record_key, seat_count, output ready);
endinterface
`default_nettype wire

>>> rtl/krt_res_if.sv
// result channel of the keyed record table
`default_nettype none
interface krt_res_if import krt_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [KEY_W-1:0] found_key;
  logic [SEAT_W-1:0]       found_seats;
  logic [SLOT_W-1:0]       slot_position;
  logic [COUNT_W-1:0]      entries_held;
  logic                    last_result;

  modport source (output valid, status, found_key, found_seats, slot_position,
                  entries_held, last_result, input ready);
  modport sink (input valid, status, found_key, found_seats, slot_position,
                entries_held, last_result, output ready);
endinterface
`default_nettype wire

>>> rtl/krt_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/krt_out_reg.sv
// one-entry output register that drives the result channel
`default_nettype none
module krt_out_reg import krt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t din,
  output logic         can_load,
  krt_res_if.source    res
);

  logic    full;
  result_t hold;

  // free when empty or when the held item leaves this cycle
  assign can_load = !full || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (res.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= din;
    end
  end

  assign res.valid         = full;
  assign res.status        = hold.status;
  assign res.found_key     = hold.found_key;
  assign res.found_seats   = hold.found_seats;
  assign res.slot_position = hold.slot_position;
  assign res.entries_held  = hold.entries_held;
  assign res.last_result   = hold.last_result;

endmodule
`default_nettype wire

>>> rtl/keyed_record_table.sv
// keyed record table: top level with command sequencer and record memory
// Holds up to TABLE_DEPTH (key, seats) records in insertion order in one
// synchronous ram, one record per word, with a fill count in a register; the
// ram needs no clearing after reset. Commands are taken one at a time, and a
// new command is accepted only once the previous one is finished and the
// output register is free. An insert, and a search, delete or dump on an
// empty table, give their result straight from the idle state; a search
// scans the records from the oldest up to the first hit or the last record;
// a delete runs the same scan, then moves each later record down one slot to
// close the gap; a dump reads out every record in order and holds while the
// result side stalls. With the single read port of the record ram, the scan,
// the compaction and the dump each move one record per cycle, the dump only
// while the output register can take a result.
`default_nettype none
module keyed_record_table import krt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  krt_cmd_if.sink   cmd,
  krt_res_if.source res
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = KEY_W + SEAT_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DUMP  = 2'd3;

  // control registers
  logic [1:0]    state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] idx, idx_next;
  logic          is_del, is_del_next;
  // key being looked up by a search or delete
  logic signed [KEY_W-1:0] cmd_key, cmd_key_next;

  // ram port signals
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;

  // output register hookup
  logic    load, can_load;
  result_t dout;

  logic                    accept;
  logic signed [KEY_W-1:0] rd_key;
  logic [SEAT_W-1:0]       rd_seats;
  logic [CW-1:0]           idx_inc;
  logic [CW-1:0]           idx_inc2;

  assign rd_key   = rdata[RW-1:SEAT_W];
  assign rd_seats = rdata[SEAT_W-1:0];
  assign idx_inc  = idx + CW'(1);
  assign idx_inc2 = idx + CW'(2);

  // commands are taken only between commands, with room for the result
  assign cmd.ready = (state == S_IDLE) && can_load;
  assign accept    = cmd.valid && cmd.ready;

  krt_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  krt_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .din      (dout),
    .can_load (can_load),
    .res      (res)
  );

  always_comb begin
    state_next   = state;
    fill_next    = fill;
    idx_next     = idx;
    is_del_next  = is_del;
    cmd_key_next = cmd_key;
    we           = 1'b0;
    waddr        = idx[AW-1:0];
    wdata        = rdata;
    raddr        = idx_inc[AW-1:0];
    load         = 1'b0;
    dout         = '0;
    dout.entries_held = COUNT_W'(fill);
    dout.last_result  = 1'b1;

    unique case (state)
      S_IDLE: begin
        // start every lookup at the oldest record
        raddr = '0;
        if (accept) begin
          idx_next     = '0;
          cmd_key_next = cmd.record_key;
          unique case (cmd.kind)
            KIND_INSERT: begin
              load = 1'b1;
              if (fill == FULL_COUNT) begin
                dout.status = ST_FULL;
              end else begin
                we                 = 1'b1;
                waddr              = fill[AW-1:0];
                wdata              = {cmd.record_key, cmd.seat_count};
                fill_next          = fill + CW'(1);
                dout.status        = ST_OK;
                dout.found_key     = cmd.record_key;
                dout.found_seats   = cmd.seat_count;
                dout.slot_position = SLOT_W'(fill);
                dout.entries_held  = COUNT_W'(fill + CW'(1));
              end
            end
            KIND_SEARCH, KIND_DELETE: begin
              is_del_next = (cmd.kind == KIND_DELETE);
              if (fill == '0) begin
                load        = 1'b1;
                dout.status = ST_NOT_FOUND;
              end else begin
                state_next = S_SCAN;
              end
            end
            KIND_DUMP: begin
              if (fill == '0) begin
                load        = 1'b1;
                dout.status = ST_EMPTY;
              end else begin
                state_next = S_DUMP;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // rdata holds record idx; the read of idx + 1 is already on its way
        if (rd_key == cmd_key) begin
          load               = 1'b1;
          dout.status        = ST_OK;
          dout.found_key     = rd_key;
          dout.found_seats   = rd_seats;
          dout.slot_position = SLOT_W'(idx);
          if (is_del) begin
            fill_next         = fill - CW'(1);
            dout.entries_held = COUNT_W'(fill - CW'(1));
            state_next        = S_SHIFT;
          end else begin
            state_next = S_IDLE;
          end
        end else if (idx_inc == fill) begin
          load        = 1'b1;
          dout.status = ST_NOT_FOUND;
          state_next  = S_IDLE;
        end else begin
          idx_next = idx_inc;
        end
      end

      S_SHIFT: begin
        // rdata holds record idx + 1, which moves down into slot idx
        raddr = idx_inc2[AW-1:0];
        if (idx < fill) begin
          we       = 1'b1;
          idx_next = idx_inc;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_DUMP: begin
        // on a stall the same record is read again so rdata stays put
        if (can_load) begin
          load               = 1'b1;
          dout.status        = ST_OK;
          dout.found_key     = rd_key;
          dout.found_seats   = rd_seats;
          dout.slot_position = SLOT_W'(idx);
          dout.last_result   = (idx_inc == fill);
          if (idx_inc == fill) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx_inc;
          end
        end else begin
          raddr = idx[AW-1:0];
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    is_del  <= is_del_next;
    cmd_key <= cmd_key_next;
  end

endmodule
`default_nettype wire

>>> tb/tb_keyed_record_table.sv
// self-checking testbench of the keyed record table: directed and random commands
`default_nettype none
module tb_keyed_record_table;
  import krt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 124;
  // a delete may still be compacting after its result leaves, so the drain
  // covers a full scan plus a full shift of the table
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
  // receiver hold-off during the back-pressure test, in clock cycles
  localparam int HOLD_CYCLES  = 300;
  // generous bound: every item a full dump with every result long-stalled,
  // taken several times over
  localparam longint TIMEOUT_NS = 64'd20_000_000;
  localparam int MAX_REPORTS  = 10;

  logic clk = 1'b0;
  logic rst;

  krt_cmd_if cmd_bus ();
  krt_res_if res_bus ();

  keyed_record_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .res(res_bus)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor state: shadow copy of the record table
  // ---------------------------------------------------------------------
  logic signed [KEY_W-1:0] rec_keys [TABLE_DEPTH];
  logic [SEAT_W-1:0]       rec_seats [TABLE_DEPTH];
  int                      rec_fill;

  // results still owed by the block, oldest first
  result_t pending_results [$];
  int      mismatch_count;

  // knobs shared between the test tasks and the handshake processes
  bit sender_idling;   // 0 gives back-to-back items on the command side
  int hold_request;    // a positive value asks the receiver for a long hold-off

  function automatic result_t make_result(input logic [STAT_W-1:0] st,
                                          input logic signed [KEY_W-1:0] key,
                                          input logic [SEAT_W-1:0] seats,
                                          input int slot, input bit last);
    result_t r;
    r.status        = st;
    r.found_key     = key;
    r.found_seats   = seats;
    r.slot_position = SLOT_W'(slot);
    r.entries_held  = COUNT_W'(rec_fill);
    r.last_result   = last;
    return r;
  endfunction

  // position of the oldest record holding key, or -1
  function automatic int oldest_match(input logic signed [KEY_W-1:0] key);
    int hit;
    hit = -1;
    for (int i = 0; i < rec_fill; i++)
      if (hit < 0 && rec_keys[i] == key) hit = i;
    return hit;
  endfunction

  // advance the shadow table by one accepted command and queue its results
  task automatic predict_table_cmd(input logic [KIND_W-1:0] kind,
                                   input logic signed [KEY_W-1:0] key,
                                   input logic [SEAT_W-1:0] seats);
    int hit;
    logic signed [KEY_W-1:0] gone_key;
    logic [SEAT_W-1:0] gone_seats;
    case (kind)
      KIND_INSERT: begin
        if (rec_fill >= TABLE_DEPTH) begin
          // full table: refused, nothing changes
          pending_results.push_back(make_result(ST_FULL, '0, '0, 0, 1'b1));
        end else begin
          rec_keys[rec_fill]  = key;
          rec_seats[rec_fill] = seats;
          rec_fill++;
          pending_results.push_back(make_result(ST_OK, key, seats, rec_fill - 1, 1'b1));
        end
      end
      KIND_SEARCH: begin
        hit = oldest_match(key);
        if (hit < 0)
          pending_results.push_back(make_result(ST_NOT_FOUND, '0, '0, 0, 1'b1));
        else
          pending_results.push_back(make_result(ST_OK, rec_keys[hit], rec_seats[hit],
                                                hit, 1'b1));
      end
      KIND_DELETE: begin
        hit = oldest_match(key);
        if (hit < 0) begin
          pending_results.push_back(make_result(ST_NOT_FOUND, '0, '0, 0, 1'b1));
        end else begin
          gone_key   = rec_keys[hit];
          gone_seats = rec_seats[hit];
          // close the gap, keeping insertion order
          for (int i = hit; i < rec_fill - 1; i++) begin
            rec_keys[i]  = rec_keys[i + 1];
            rec_seats[i] = rec_seats[i + 1];
          end
          rec_fill--;
          pending_results.push_back(make_result(ST_OK, gone_key, gone_seats, hit, 1'b1));
        end
      end
      default: begin
        if (rec_fill == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, '0, '0, 0, 1'b1));
        end else begin
          for (int i = 0; i < rec_fill; i++)
            pending_results.push_back(make_result(ST_OK, rec_keys[i], rec_seats[i], i,
                                                  i == rec_fill - 1));
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // half the time a key that is stored, else a small pool or a full-width value
  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50 && rec_fill > 0) return rec_keys[$urandom_range(0, rec_fill - 1)];
    if (r < 75) return KEY_W'($urandom_range(0, 15));
    return $urandom;
  endfunction

  function automatic logic [SEAT_W-1:0] pick_seats();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return SEAT_W'($urandom_range(0, 65535));
  endfunction

  // fewer inserts near the top so the table hovers around full without sticking
  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    int ins_w;
    r = $urandom_range(0, 99);
    ins_w = (rec_fill >= TABLE_DEPTH - 4) ? 20 : 40;
    if (r < 6) return KIND_DUMP;
    if (r < 6 + ins_w) return KIND_INSERT;
    if (r < 6 + ins_w + (94 - ins_w) / 2) return KIND_SEARCH;
    return KIND_DELETE;
  endfunction

  // ---------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------

  // offer one item, hold it until accepted, then predict; returns right after
  // the accepting edge with valid still high so the next item can follow
  task automatic send_cmd(input logic [KIND_W-1:0] kind,
                          input logic signed [KEY_W-1:0] key,
                          input logic [SEAT_W-1:0] seats);
    int gap;
    gap = sender_idling ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      cmd_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_bus.valid      <= 1'b1;
    cmd_bus.kind       <= kind;
    cmd_bus.record_key <= key;
    cmd_bus.seat_count <= seats;
    do @(posedge clk); while (!cmd_bus.ready);
    predict_table_cmd(kind, key, seats);
  endtask

  // drop valid before anything that lets time pass without a new item
  task automatic idle_cmd();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // result side: random ready with quiet stretches and long hold-offs
  // ---------------------------------------------------------------------
  initial begin : drive_ready
    int gap;
    int quiet_left;
    quiet_left    = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        // long hold-off, counted here so the command side keeps pushing
        res_bus.ready <= 1'b0;
        for (int c = 1; c < hold_request; c++) @(negedge clk);
        hold_request = 0;
      end else if (quiet_left > 0) begin
        res_bus.ready <= 1'b1;
        quiet_left--;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          res_bus.ready <= 1'b1;
          if ($urandom_range(0, 49) == 0) quiet_left = 60;
        end else begin
          res_bus.ready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // result checking against the oldest expectation
  // ---------------------------------------------------------------------
  task automatic log_mismatch(input string what, input result_t want, input result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t %s: expected st=%0d key=%h seats=%h slot=%0d held=%0d last=%0b",
               $realtime, what,
               want.status, want.found_key, want.found_seats, want.slot_position,
               want.entries_held, want.last_result);
      $display("    got st=%0d key=%h seats=%h slot=%0d held=%0d last=%0b",
               got.status, got.found_key, got.found_seats, got.slot_position,
               got.entries_held, got.last_result);
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      got.status        = res_bus.status;
      got.found_key     = res_bus.found_key;
      got.found_seats   = res_bus.found_seats;
      got.slot_position = res_bus.slot_position;
      got.entries_held  = res_bus.entries_held;
      got.last_result   = res_bus.last_result;
      if (pending_results.size() == 0) begin
        log_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.found_key !== want.found_key ||
            got.found_seats !== want.found_seats ||
            got.slot_position !== want.slot_position ||
            got.entries_held !== want.entries_held ||
            got.last_result !== want.last_result)
          log_mismatch("result mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // dump, search and delete on a table that holds nothing
  task automatic test_empty_table();
    send_cmd(KIND_DUMP, '0, '0);
    send_cmd(KIND_SEARCH, '0, '0);
    send_cmd(KIND_DELETE, -32'sd1, '1);
  endtask

  // extreme keys and seats, a duplicate key, hits and a miss
  task automatic test_insert_search();
    send_cmd(KIND_INSERT, 32'sh8000_0000, 16'h0000);
    send_cmd(KIND_INSERT, 32'sh7fff_ffff, 16'hffff);
    send_cmd(KIND_INSERT, 32'sh0000_0000, 16'h1234);
    send_cmd(KIND_INSERT, -32'sd1, 16'haaaa);
    send_cmd(KIND_INSERT, 32'sh7fff_ffff, 16'h5555);   // duplicate key
    send_cmd(KIND_INSERT, 32'sh1234_5678, 16'h8000);
    send_cmd(KIND_SEARCH, 32'sh7fff_ffff, '0);         // oldest of the two
    send_cmd(KIND_SEARCH, -32'sd1, '0);
    send_cmd(KIND_SEARCH, 32'sh8000_0000, '0);
    send_cmd(KIND_SEARCH, 32'sh1111_1111, '0);         // miss
    send_cmd(KIND_DUMP, '0, '0);
  endtask

  // deletes at the front, middle and end; the duplicate moves up
  task automatic test_delete_compact();
    send_cmd(KIND_DELETE, 32'sh7fff_ffff, '0);
    send_cmd(KIND_SEARCH, 32'sh7fff_ffff, '0);
    send_cmd(KIND_DELETE, 32'sh8000_0000, '0);
    send_cmd(KIND_DELETE, 32'sh1234_5678, '0);
    send_cmd(KIND_DELETE, 32'sd42, '0);                // miss
    send_cmd(KIND_DUMP, '0, '0);
  endtask

  // fill up, insert into a full table, dump all of it, then free a few slots
  task automatic test_full_table();
    while (rec_fill < TABLE_DEPTH) send_cmd(KIND_INSERT, $urandom, pick_seats());
    send_cmd(KIND_INSERT, $urandom, pick_seats());
    send_cmd(KIND_INSERT, '1, '1);
    send_cmd(KIND_SEARCH, rec_keys[TABLE_DEPTH - 1], '0);
    send_cmd(KIND_DUMP, '0, '0);
    send_cmd(KIND_DELETE, rec_keys[TABLE_DEPTH - 1], '0);
    send_cmd(KIND_INSERT, $urandom, pick_seats());
    send_cmd(KIND_DELETE, rec_keys[0], '0);
    send_cmd(KIND_DELETE, rec_keys[rec_fill / 2], '0);
  endtask

  // receiver stops for a long stretch while items keep coming, so the block
  // backs up and has to stall its command input
  task automatic test_back_pressure();
    bit saved;
    saved         = sender_idling;
    sender_idling = 1'b0;
    hold_request  = HOLD_CYCLES;
    for (int i = 0; i < 8; i++) send_cmd(KIND_SEARCH, pick_key(), '0);
    send_cmd(KIND_DUMP, '0, '0);
    for (int i = 0; i < 8; i++) send_cmd(pick_kind(), pick_key(), pick_seats());
    sender_idling = saved;
  endtask

  // mixed random commands, in stretches with and without sender gaps
  task automatic test_random_mix();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) sender_idling = ($urandom_range(0, 2) != 0);
      send_cmd(pick_kind(), pick_key(), pick_seats());
    end
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------
  initial begin
    rst                = 1'b1;
    cmd_bus.valid      = 1'b0;
    cmd_bus.kind       = KIND_INSERT;
    cmd_bus.record_key = '0;
    cmd_bus.seat_count = '0;
    rec_fill           = 0;
    mismatch_count     = 0;
    sender_idling      = 1'b1;
    hold_request       = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_insert_search();
    test_delete_compact();
    test_full_table();
    test_back_pressure();
    test_random_mix();
    idle_cmd();

    // let every owed result arrive, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
